// ===== sv/ffci_pkg.sv =====
// Shared types and constants for the face flux cell integrator.
package ffci_pkg;

   localparam int CellCount = 4096;
   localparam int CellBits  = (CellCount > 1) ? $clog2(CellCount) : 1;
   localparam int SumBits   = 48;
   localparam int FluxBits  = 32;
   localparam int VolBits   = 32;
   localparam int SclBits   = 24;
   localparam int LaneCount = 3;

   localparam logic [1:0] CMD_INTERNAL = 2'd0;
   localparam logic [1:0] CMD_BOUNDARY = 2'd1;
   localparam logic [1:0] CMD_FINISH   = 2'd2;

   typedef struct packed {
      logic [FluxBits-1:0] value;
      logic                sat;
   } lane_result_type;

endpackage

// ===== sv/ffci_ram.sv =====
// Generic single-port RAM with registered read.
module ffci_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ===== sv/ffci_lane.sv =====
// One lane: sum times scaling divided by volume, one quotient bit a cycle.
module ffci_lane import ffci_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [SumBits-1:0]         sum,
   input  logic [SclBits-1:0]         scaling,
   input  logic [VolBits-1:0]         volume,
   output logic                       done,
   output lane_result_type            result
);

   localparam int ProdBits = SumBits + SclBits;
   localparam int CntBits  = $clog2(ProdBits + 2);
   localparam int PartBits = 2 * SclBits;

   typedef enum logic [2:0] {S_IDLE, S_MUL_LO, S_MUL_HI, S_DIV, S_OUT} state_type;

   state_type            state_ff;
   logic [CntBits-1:0]   cnt_ff;
   logic [ProdBits-1:0]  prod_ff;
   logic [ProdBits-1:0]  quo_ff;
   logic [VolBits:0]     rem_ff;
   logic                 neg_ff;
   logic [SumBits-1:0]   mag_a_ff;
   logic [SclBits-1:0]   mag_b_ff;
   logic [VolBits-1:0]   vol_ff;
   logic                 done_ff;
   lane_result_type      result_ff;

   logic [VolBits:0]     rem_sh;
   logic                 fits;
   logic [ProdBits-1:0]  lim;
   logic [SclBits-1:0]   mul_a;
   logic [PartBits-1:0]  part;

   always_comb begin
      rem_sh = {rem_ff[VolBits-1:0], prod_ff[ProdBits-1]};
      fits   = rem_sh >= {1'b0, vol_ff};
      lim    = neg_ff ? ProdBits'(64'h8000_0000) : ProdBits'(64'h7FFF_FFFF);
      // one 24 by 24 multiplier, low half of the sum first, then the high half
      mul_a  = (state_ff == S_MUL_LO) ? mag_a_ff[SclBits-1:0] : mag_a_ff[SumBits-1:SclBits];
      part   = mul_a * mag_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (go) begin
                  neg_ff   <= sum[SumBits-1] ^ scaling[SclBits-1];
                  mag_a_ff <= sum[SumBits-1] ? -sum : sum;
                  mag_b_ff <= scaling[SclBits-1] ? -scaling : scaling;
                  vol_ff   <= volume;
                  state_ff <= S_MUL_LO;
               end
            end
            S_MUL_LO: begin
               prod_ff  <= {{(ProdBits-PartBits){1'b0}}, part};
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               prod_ff  <= prod_ff + {part, {SclBits{1'b0}}};
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= CntBits'(ProdBits);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle
               rem_ff  <= fits ? rem_sh - {1'b0, vol_ff} : rem_sh;
               quo_ff  <= {quo_ff[ProdBits-2:0], fits};
               prod_ff <= {prod_ff[ProdBits-2:0], 1'b0};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == CntBits'(1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (quo_ff > lim) begin
                  result_ff.sat   <= 1'b1;
                  result_ff.value <= lim[FluxBits-1:0];
               end else begin
                  result_ff.sat   <= 1'b0;
                  result_ff.value <= neg_ff ? -quo_ff[FluxBits-1:0] : quo_ff[FluxBits-1:0];
               end
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== sv/face_flux_cell_integrator.sv =====
// Top level: per-cell flux accumulation with scaled, volume-divided emission.
//
// Request channel: drive req_* and raise start while busy is low; the request
// is taken at that edge. command 0 adds the flux to cell_a and subtracts it
// from cell_b, command 1 adds it to cell_a, command 2 finishes cell_a, and
// command 3 is dropped.
// A boundary request holds busy through a read and a write back of cell_a,
// an internal request through those and then a read and write back of
// cell_b (owner, then neighbour), one RAM port per component; the next
// request is taken only once busy is low again. A finish request holds busy
// while it reads the sums and writes the cleared entry back, then runs three
// lanes in parallel, each a multiply in two halves, a restoring divide and
// an output step, then the merge. Its result is on rsp_* when busy is already
// low. A zero volume skips the lanes; its result also comes with busy low.
// Results appear on rsp_* for one cycle with rsp_valid high; the receiver
// cannot stall, so no further buffering exists.
// After reset a clearing pass over all CellCount entries zeroes the sums;
// busy is high during it.
module face_flux_cell_integrator import ffci_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [11:0]                req_cell_a,
   input  logic [11:0]                req_cell_b,
   input  logic signed [31:0]         req_flux_x,
   input  logic signed [31:0]         req_flux_y,
   input  logic signed [31:0]         req_flux_z,
   input  logic [31:0]                req_volume,
   input  logic signed [23:0]         req_scaling,
   output logic                       rsp_valid,
   output logic [11:0]                rsp_cell_index,
   output logic signed [31:0]         rsp_value_x,
   output logic signed [31:0]         rsp_value_y,
   output logic signed [31:0]         rsp_value_z,
   output logic                       rsp_divide_by_zero,
   output logic                       rsp_saturated
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_A, S_WR_A, S_RD_B, S_WR_B, S_F_RD, S_F_WAIT,
      S_F_GO, S_F_RUN, S_F_EMIT
   } state_type;

   state_type             state_ff;
   logic [CellBits:0]     clr_ff;
   logic [1:0]            cmd_ff;
   logic [11:0]           ca_ff;
   logic [11:0]           cb_ff;
   logic [FluxBits-1:0]   flux_ff [LaneCount];
   logic [VolBits-1:0]    vol_ff;
   logic [SclBits-1:0]    scl_ff;
   logic                  rsp_valid_ff;
   logic [FluxBits-1:0]   val_ff [LaneCount];
   logic                  dz_ff;
   logic                  sat_ff;

   logic                  wr_en;
   logic [CellBits-1:0]   addr;
   logic [SumBits-1:0]    wr_data [LaneCount];
   logic [SumBits-1:0]    rd_data [LaneCount];
   logic                  lane_go;
   logic [LaneCount-1:0]  lane_done;
   lane_result_type       lane_res [LaneCount];

   logic                  a_ok;
   logic                  b_ok;
   assign a_ok = 32'(req_cell_a) < CellCount;
   assign b_ok = 32'(cb_ff) < CellCount;

   always_comb begin
      wr_en = 1'b0;
      addr  = CellBits'(ca_ff);
      for (int i = 0; i < LaneCount; i++) begin
         wr_data[i] = rd_data[i] + {{(SumBits-FluxBits){flux_ff[i][FluxBits-1]}}, flux_ff[i]};
      end
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr  = clr_ff[CellBits-1:0];
            for (int i = 0; i < LaneCount; i++) wr_data[i] = '0;
         end
         S_WR_A: wr_en = 1'b1;
         S_RD_B: addr = CellBits'(cb_ff);
         S_WR_B: begin
            wr_en = 1'b1;
            addr  = CellBits'(cb_ff);
            for (int i = 0; i < LaneCount; i++) begin
               wr_data[i] = rd_data[i]
                  - {{(SumBits-FluxBits){flux_ff[i][FluxBits-1]}}, flux_ff[i]};
            end
         end
         S_F_GO: begin
            wr_en = 1'b1;
            for (int i = 0; i < LaneCount; i++) wr_data[i] = '0;
         end
         default: ;
      endcase
   end

   assign lane_go = (state_ff == S_F_GO) && (vol_ff != '0);

   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      ffci_ram #(.Width(SumBits), .Depth(CellCount)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .addr    (addr),
         .wr_data (wr_data[g]),
         .rd_data (rd_data[g])
      );
      ffci_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .go      (lane_go),
         .sum     (rd_data[g]),
         .scaling (scl_ff),
         .volume  (vol_ff),
         .done    (lane_done[g]),
         .result  (lane_res[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (CellBits+1)'(CellCount - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  cmd_ff     <= req_command;
                  ca_ff      <= req_cell_a;
                  cb_ff      <= req_cell_b;
                  flux_ff[0] <= req_flux_x;
                  flux_ff[1] <= req_flux_y;
                  flux_ff[2] <= req_flux_z;
                  vol_ff     <= req_volume;
                  scl_ff     <= req_scaling;
                  case (req_command)
                     CMD_INTERNAL, CMD_BOUNDARY:
                        state_ff <= a_ok ? S_RD_A
                                  : (req_command == CMD_INTERNAL ? S_RD_B : S_IDLE);
                     CMD_FINISH: begin
                        if (a_ok) begin
                           state_ff <= S_F_RD;
                        end else begin
                           // out-of-range cell: emit zeros
                           rsp_valid_ff <= 1'b1;
                           for (int i = 0; i < LaneCount; i++) val_ff[i] <= '0;
                           dz_ff  <= 1'b0;
                           sat_ff <= 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RD_A: state_ff <= S_WR_A;
            S_WR_A: state_ff <= (cmd_ff == CMD_INTERNAL) ? S_RD_B : S_IDLE;
            S_RD_B: state_ff <= b_ok ? S_WR_B : S_IDLE;
            S_WR_B: state_ff <= S_IDLE;
            S_F_RD: state_ff <= S_F_WAIT;
            S_F_WAIT: state_ff <= S_F_GO;
            S_F_GO: begin
               if (vol_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  for (int i = 0; i < LaneCount; i++) val_ff[i] <= '0;
                  dz_ff    <= 1'b1;
                  sat_ff   <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_F_RUN;
               end
            end
            S_F_RUN: begin
               if (&lane_done) state_ff <= S_F_EMIT;
            end
            S_F_EMIT: begin
               // merge the lanes
               rsp_valid_ff <= 1'b1;
               for (int i = 0; i < LaneCount; i++) val_ff[i] <= lane_res[i].value;
               dz_ff    <= 1'b0;
               sat_ff   <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_index     = ca_ff;
   assign rsp_value_x        = val_ff[0];
   assign rsp_value_y        = val_ff[1];
   assign rsp_value_z        = val_ff[2];
   assign rsp_divide_by_zero = dz_ff;
   assign rsp_saturated      = sat_ff;

endmodule

// ===== tb/face_flux_cell_integrator_tb.sv =====
// Self-checking testbench for the face flux cell integrator.
`timescale 1ns / 1ps

module face_flux_cell_integrator_tb;
   import ffci_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] cell_a;
      logic [11:0] cell_b;
      logic [31:0] flux_x;
      logic [31:0] flux_y;
      logic [31:0] flux_z;
      logic [31:0] volume;
      logic [23:0] scaling;
   } face_req_type;

   typedef struct packed {
      logic [11:0] cell_index;
      logic [31:0] value_x;
      logic [31:0] value_y;
      logic [31:0] value_z;
      logic        divide_by_zero;
      logic        saturated;
   } cell_rsp_type;

   class cell_sum_board;
      logic [SumBits-1:0] sum_x [CellCount];
      logic [SumBits-1:0] sum_y [CellCount];
      logic [SumBits-1:0] sum_z [CellCount];
      cell_rsp_type pending [$];
      int mismatches = 0;
      int faces = 0, finishes = 0, zero_vol = 0, clamped = 0;

      function new();
         for (int i = 0; i < CellCount; i++) begin
            sum_x[i] = '0;
            sum_y[i] = '0;
            sum_z[i] = '0;
         end
      endfunction

      static function logic [SumBits-1:0] widen(input logic [31:0] f);
         return {{(SumBits-32){f[31]}}, f};
      endfunction

      // sum * scaling / volume, truncated toward zero, clamped to 32 bits
      static function logic [31:0] scale_divide(input logic [47:0] s, input logic [23:0] c,
                                                input logic [31:0] v, inout bit sat);
         logic        neg;
         logic [47:0] a;
         logic [23:0] b;
         logic [71:0] p, q, lim;
         neg = s[47] ^ c[23];
         a = s[47] ? -s : s;
         b = c[23] ? -c : c;
         p = {24'b0, a} * {48'b0, b};
         q = p / {40'b0, v};
         lim = neg ? 72'h80000000 : 72'h7FFFFFFF;
         if (q > lim) begin
            q = lim;
            sat = 1;
         end
         return neg ? -q[31:0] : q[31:0];
      endfunction

      function void note_request(input face_req_type r);
         cell_rsp_type e;
         bit sat;
         case (r.command)
            CMD_INTERNAL, CMD_BOUNDARY: begin
               faces++;
               sum_x[r.cell_a] = sum_x[r.cell_a] + widen(r.flux_x);
               sum_y[r.cell_a] = sum_y[r.cell_a] + widen(r.flux_y);
               sum_z[r.cell_a] = sum_z[r.cell_a] + widen(r.flux_z);
               if (r.command == CMD_INTERNAL) begin
                  sum_x[r.cell_b] = sum_x[r.cell_b] - widen(r.flux_x);
                  sum_y[r.cell_b] = sum_y[r.cell_b] - widen(r.flux_y);
                  sum_z[r.cell_b] = sum_z[r.cell_b] - widen(r.flux_z);
               end
            end
            CMD_FINISH: begin
               finishes++;
               sat = 0;
               e.cell_index = r.cell_a;
               e.divide_by_zero = (r.volume == 0);
               if (r.volume == 0) begin
                  zero_vol++;
                  e.value_x = '0;
                  e.value_y = '0;
                  e.value_z = '0;
               end else begin
                  e.value_x = scale_divide(sum_x[r.cell_a], r.scaling, r.volume, sat);
                  e.value_y = scale_divide(sum_y[r.cell_a], r.scaling, r.volume, sat);
                  e.value_z = scale_divide(sum_z[r.cell_a], r.scaling, r.volume, sat);
               end
               e.saturated = sat;
               if (sat) clamped++;
               sum_x[r.cell_a] = '0;
               sum_y[r.cell_a] = '0;
               sum_z[r.cell_a] = '0;
               pending.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(input cell_rsp_type a);
         cell_rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result for cell %0d", a.cell_index);
            return;
         end
         e = pending.pop_front();
         if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp cell %0d x %h y %h z %h dz %b sat %b",
                         " | got cell %0d x %h y %h z %h dz %b sat %b"},
                        e.cell_index, e.value_x, e.value_y, e.value_z, e.divide_by_zero,
                        e.saturated, a.cell_index, a.value_x, a.value_y, a.value_z,
                        a.divide_by_zero, a.saturated);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0]         req_command = '0;
   logic [11:0]        req_cell_a = '0;
   logic [11:0]        req_cell_b = '0;
   logic signed [31:0] req_flux_x = '0;
   logic signed [31:0] req_flux_y = '0;
   logic signed [31:0] req_flux_z = '0;
   logic [31:0]        req_volume = '0;
   logic signed [23:0] req_scaling = '0;
   logic               rsp_valid;
   logic [11:0]        rsp_cell_index;
   logic signed [31:0] rsp_value_x, rsp_value_y, rsp_value_z;
   logic               rsp_divide_by_zero, rsp_saturated;

   cell_sum_board board = new();
   int burst_left = 0;

   face_flux_cell_integrator uut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("[face_flux_cell_integrator] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      face_req_type r;
      cell_rsp_type a;
      if (!reset) begin
         if (start && !busy) begin
            r.command = req_command;
            r.cell_a = req_cell_a;
            r.cell_b = req_cell_b;
            r.flux_x = req_flux_x;
            r.flux_y = req_flux_y;
            r.flux_z = req_flux_z;
            r.volume = req_volume;
            r.scaling = req_scaling;
            board.note_request(r);
         end
         if (rsp_valid) begin
            a.cell_index = rsp_cell_index;
            a.value_x = rsp_value_x;
            a.value_y = rsp_value_y;
            a.value_z = rsp_value_z;
            a.divide_by_zero = rsp_divide_by_zero;
            a.saturated = rsp_saturated;
            board.check_result(a);
         end
      end
   end

   // Present a request and hold it until taken; called at a rising edge.
   task automatic send_request(input face_req_type r, input bit paced);
      if (paced) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
               start <= 0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_command <= r.command;
      req_cell_a <= r.cell_a;
      req_cell_b <= r.cell_b;
      req_flux_x <= r.flux_x;
      req_flux_y <= r.flux_y;
      req_flux_z <= r.flux_z;
      req_volume <= r.volume;
      req_scaling <= r.scaling;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [11:0] ca, input logic [11:0] cb,
                              input logic [31:0] fx, input logic [31:0] fy,
                              input logic [31:0] fz, input logic [31:0] vol,
                              input logic [23:0] scl);
      face_req_type r;
      r.command = cmd;
      r.cell_a = ca;
      r.cell_b = cb;
      r.flux_x = fx;
      r.flux_y = fy;
      r.flux_z = fz;
      r.volume = vol;
      r.scaling = scl;
      send_request(r, 1);
   endtask

   function automatic logic [31:0] rand_flux();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom();
         default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic logic [31:0] rand_volume();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'd1;
         2: return 32'hFFFFFFFF;
         3: return $urandom();
         default: return $urandom_range(32'h00004000, 32'h00080000);
      endcase
   endfunction

   function automatic logic [23:0] rand_scaling();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h010000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [11:0] rand_cell();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $urandom_range(0, 11);
   endfunction

   initial begin
      face_req_type r;
      logic [1:0] cmd;
      int pick, waited;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: extremes, each command, cancelling face, zero volume
      send_fields(CMD_BOUNDARY, 12'd0, 12'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                  '0, '0);
      send_fields(CMD_FINISH, 12'd0, 12'd0, '0, '0, '0, 32'd1, 24'h7FFFFF);
      send_fields(CMD_INTERNAL, 12'd4095, 12'd1, 32'h00010000, 32'hFFFF0000, 32'h12345678,
                  '0, '0);
      send_fields(CMD_FINISH, 12'd4095, 12'd0, '0, '0, '0, 32'h00010000, 24'h010000);
      send_fields(CMD_FINISH, 12'd1, 12'd0, '0, '0, '0, 32'hFFFFFFFF, 24'h800000);
      send_fields(CMD_INTERNAL, 12'd5, 12'd5, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                  '0, '0);
      send_fields(CMD_FINISH, 12'd5, 12'd0, '0, '0, '0, 32'd3, 24'h7FFFFF);
      send_fields(CMD_BOUNDARY, 12'd6, 12'd0, 32'h00020000, 32'd7, 32'h80000000, '0, '0);
      send_fields(CMD_FINISH, 12'd6, 12'd0, '0, '0, '0, '0, 24'h7FFFFF);
      send_fields(CMD_FINISH, 12'd6, 12'd0, '0, '0, '0, 32'h00010000, 24'h010000);
      send_fields(CMD_UNUSED, 12'd6, 12'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 24'hFFFFFF);
      send_fields(CMD_FINISH, 12'd7, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 24'hFFFFFF);

      // pile large fluxes into one cell, back to back
      r.command = CMD_BOUNDARY;
      r.cell_a = 12'd8;
      r.cell_b = '0;
      r.flux_x = 32'h7FFFFFFF;
      r.flux_y = 32'h80000000;
      r.flux_z = 32'h7FFFFFFF;
      r.volume = '0;
      r.scaling = '0;
      for (int i = 0; i < 48; i++) send_request(r, 0);
      send_fields(CMD_FINISH, 12'd8, 12'd0, '0, '0, '0, 32'h00010000, 24'h010000);

      for (int i = 0; i < 2000; i++) begin
         pick = $urandom_range(0, 99);
         cmd = (pick < 55) ? CMD_INTERNAL : (pick < 78) ? CMD_BOUNDARY :
               (pick < 96) ? CMD_FINISH : CMD_UNUSED;
         send_fields(cmd, rand_cell(), rand_cell(), rand_flux(),
                     ($urandom_range(0, 3) == 0) ? 32'h0 : rand_flux(), rand_flux(),
                     rand_volume(), rand_scaling());
      end
      start <= 0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      $display("covered %0d face requests and %0d finishes (%0d zero volume, %0d clamped)",
               board.faces, board.finishes, board.zero_vol, board.clamped);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[face_flux_cell_integrator] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("[face_flux_cell_integrator] ERROR");
      end
      $finish;
   end

endmodule
